// File: design/icpp_pkg.sv
// Shared types, constants and helpers for the point projection pipeline.
`default_nettype none
package icpp_pkg;

    // Rotation matrix entry: Q14, wide enough for non-unit quaternions
    localparam int ENT_W = 20;
    // Fraction bits of Q2.14 values and the rounding half
    localparam int FRAC = 14;
    localparam int RND_HALF = 8192;
    // Quotient bits resolved by the divider; anything larger saturates
    localparam int QBITS = 18;

    // Configuration register indexes
    localparam logic [2:0] CFG_FOCAL_X = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_EXT_ROT = 3'd4;
    localparam logic [2:0] CFG_EXT_TRANS = 3'd5;

    typedef logic signed [ENT_W-1:0] t_ent;

    // Clamp a signed value to a signed range of the given width
    function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                 input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: design/icpp_in_if.sv
// Input channel: attitude quaternion and IMU-frame point.
`default_nettype none
interface icpp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] att_w;
    logic signed [15:0] att_x;
    logic signed [15:0] att_y;
    logic signed [15:0] att_z;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;

    modport source (output valid, att_w, att_x, att_y, att_z, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, att_w, att_x, att_y, att_z, point_x, point_y, point_z,
                  output ready);
endinterface
`default_nettype wire

// File: design/icpp_out_if.sv
// Output channel: projected pixel and flags.
`default_nettype none
interface icpp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
    logic               behind_camera;
    logic               clipped;

    modport source (output valid, pixel_u, pixel_v, behind_camera, clipped, input ready);
    modport sink (input valid, pixel_u, pixel_v, behind_camera, clipped, output ready);
endinterface
`default_nettype wire

// File: design/icpp_qmat.sv
// Quaternion to rotation matrix, two register stages.
`default_nettype none
module icpp_qmat (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [15:0]  i_w,
    input  wire logic signed [15:0]  i_x,
    input  wire logic signed [15:0]  i_y,
    input  wire logic signed [15:0]  i_z,
    output icpp_pkg::t_ent           o_mat [9]
);
    localparam int SW = 35;
    localparam logic signed [SW-1:0] ONE = SW'(64'sd1 <<< 28);

    // Products: xx yy zz xy xz yz wx wy wz
    logic signed [31:0] r_p [9];
    logic signed [SW-1:0] n_e [9];
    logic signed [SW-1:0] n_r [9];
    icpp_pkg::t_ent r_mat [9];

    // Register component products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= 32'(i_x) * 32'(i_x);
            r_p[1] <= 32'(i_y) * 32'(i_y);
            r_p[2] <= 32'(i_z) * 32'(i_z);
            r_p[3] <= 32'(i_x) * 32'(i_y);
            r_p[4] <= 32'(i_x) * 32'(i_z);
            r_p[5] <= 32'(i_y) * 32'(i_z);
            r_p[6] <= 32'(i_w) * 32'(i_x);
            r_p[7] <= 32'(i_w) * 32'(i_y);
            r_p[8] <= 32'(i_w) * 32'(i_z);
        end
    end

    // Form entries in Q28 and round to Q14
    always_comb begin
        n_e[0] = ONE - ((SW'(r_p[1]) + SW'(r_p[2])) <<< 1);
        n_e[1] = (SW'(r_p[3]) - SW'(r_p[8])) <<< 1;
        n_e[2] = (SW'(r_p[4]) + SW'(r_p[7])) <<< 1;
        n_e[3] = (SW'(r_p[3]) + SW'(r_p[8])) <<< 1;
        n_e[4] = ONE - ((SW'(r_p[0]) + SW'(r_p[2])) <<< 1);
        n_e[5] = (SW'(r_p[5]) - SW'(r_p[6])) <<< 1;
        n_e[6] = (SW'(r_p[4]) - SW'(r_p[7])) <<< 1;
        n_e[7] = (SW'(r_p[5]) + SW'(r_p[6])) <<< 1;
        n_e[8] = ONE - ((SW'(r_p[0]) + SW'(r_p[1])) <<< 1);
        for (int i = 0; i < 9; i++) begin
            n_r[i] = n_e[i] + SW'(icpp_pkg::RND_HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 9; i++) begin
                r_mat[i] <= n_r[i][icpp_pkg::FRAC+icpp_pkg::ENT_W-1:icpp_pkg::FRAC];
            end
        end
    end

    assign o_mat = r_mat;
endmodule
`default_nettype wire

// File: design/icpp_rot.sv
// Transposed matrix times vector with rounding and saturation, two stages.
`default_nettype none
module icpp_rot #(
    parameter int IW = 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire icpp_pkg::t_ent       i_mat [9],
    input  wire logic signed [IW-1:0] i_vec [3],
    output logic signed [IW-1:0]      o_vec [3]
);
    localparam int PW = icpp_pkg::ENT_W + IW;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] r_pr [9];
    logic signed [SW-1:0] n_s [3];
    logic signed [SW-1:0] n_sh [3];
    logic signed [63:0]   n_sat [3];
    logic signed [IW-1:0] r_out [3];

    // Register products, column i of the matrix against the vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i*3+j] <= PW'(i_mat[j*3+i]) * PW'(i_vec[j]);
                end
            end
        end
    end

    // Sum, round to integer and clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i] = SW'(r_pr[i*3]) + SW'(r_pr[i*3+1]) + SW'(r_pr[i*3+2])
                     + SW'(icpp_pkg::RND_HALF);
            n_sh[i] = n_s[i] >>> icpp_pkg::FRAC;
            n_sat[i] = icpp_pkg::sat64(64'(n_sh[i]), IW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= n_sat[i][IW-1:0];
            end
        end
    end

    assign o_vec = r_out;
endmodule
`default_nettype wire

// File: design/icpp_proj.sv
// Pinhole projection of one axis: multiply, pipelined rounding division, centre.
`default_nettype none
module icpp_proj #(
    parameter int IW = 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_kill,
    input  wire logic [15:0]          i_focal,
    input  wire logic [15:0]          i_center,
    input  wire logic signed [IW-1:0] i_lat,
    input  wire logic signed [IW-1:0] i_depth,
    output logic signed [15:0]        o_pix,
    output logic                      o_clip
);
    localparam int QB = icpp_pkg::QBITS;
    localparam int MW = IW + 17;
    localparam int DW = IW - 1;
    localparam int FW = QB + 2;

    // Multiply stage
    logic signed [MW-1:0] r1_num;
    logic [DW-1:0]        r1_d;
    logic [15:0]          r1_ctr;
    logic                 r1_kill;
    // Rounding offset stage
    logic [MW-1:0]        n2_mag;
    logic [MW-1:0]        r2_n;
    logic [DW-1:0]        r2_d;
    logic [15:0]          r2_ctr;
    logic                 r2_neg;
    logic                 r2_kill;
    // Divider stages, index 0 is the setup stage
    logic [DW-1:0]        r_rem  [QB+1];
    logic [QB-1:0]        r_low  [QB+1];
    logic [QB-1:0]        r_q    [QB+1];
    logic [DW-1:0]        r_d    [QB+1];
    logic [15:0]          r_ctr  [QB+1];
    logic                 r_neg  [QB+1];
    logic                 r_ovf  [QB+1];
    logic                 r_kill [QB+1];
    logic [DW:0]          n_t    [QB];
    logic                 n_ge   [QB];
    logic [DW:0]          n_rem  [QB];
    // Final stage
    logic [QB-1:0]        n_qv;
    logic signed [FW-1:0] n_sv;
    logic signed [FW-1:0] n_sum;
    logic signed [63:0]   n_sat;
    logic signed [15:0]   r_pix;
    logic                 r_clip;

    // Scale the lateral coordinate by the focal length
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_num  <= MW'($signed({1'b0, i_focal})) * MW'(i_lat);
            r1_d    <= i_depth[DW-1:0];
            r1_ctr  <= i_center;
            r1_kill <= i_kill;
        end
    end

    // Take magnitude and add half the divisor
    assign n2_mag = r1_num[MW-1] ? MW'(-r1_num) : MW'(r1_num);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_n    <= n2_mag + MW'(r1_d >> 1);
            r2_d    <= r1_d;
            r2_ctr  <= r1_ctr;
            r2_neg  <= r1_num[MW-1];
            r2_kill <= r1_kill;
        end
    end

    // Flag quotient overflow and seed the remainder with the high part
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= r2_n >= {r2_d, {QB{1'b0}}};
            r_rem[0]  <= r2_n[MW-1:QB];
            r_low[0]  <= r2_n[QB-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= r2_d;
            r_ctr[0]  <= r2_ctr;
            r_neg[0]  <= r2_neg;
            r_kill[0] <= r2_kill;
        end
    end

    // One restoring step per stage
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_t[k]   = {r_rem[k], r_low[k][QB-1]};
            n_ge[k]  = n_t[k] >= {1'b0, r_d[k]};
            n_rem[k] = n_ge[k] ? n_t[k] - {1'b0, r_d[k]} : n_t[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QB; k++) begin
                r_rem[k+1]  <= n_rem[k][DW-1:0];
                r_low[k+1]  <= {r_low[k][QB-2:0], 1'b0};
                r_q[k+1]    <= {r_q[k][QB-2:0], n_ge[k]};
                r_d[k+1]    <= r_d[k];
                r_ctr[k+1]  <= r_ctr[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_kill[k+1] <= r_kill[k];
            end
        end
    end

    // Apply sign, add centre, clamp to 16 bits
    always_comb begin
        n_qv  = r_ovf[QB] ? {QB{1'b1}} : r_q[QB];
        n_sv  = r_neg[QB] ? -$signed({2'b00, n_qv}) : $signed({2'b00, n_qv});
        n_sum = n_sv + $signed(FW'({1'b0, r_ctr[QB]}));
        n_sat = icpp_pkg::sat64(64'(n_sum), 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_kill[QB]) begin
                r_pix  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_pix  <= n_sat[15:0];
                r_clip <= n_sat != 64'(n_sum);
            end
        end
    end

    assign o_pix  = r_pix;
    assign o_clip = r_clip;
endmodule
`default_nettype wire

// File: design/imu_camera_point_projection.sv
// Top level: IMU point to camera pixel projection pipeline.
//
//  Channel   Dir   Beat contents
//  i_in      in    att_w/x/y/z (Q2.14), point_x/y/z (mm)
//  o_out     out   pixel_u, pixel_v (px*16), behind_camera, clipped
//  i_cfg_*   in    register write: index, 64-bit data
//
// One beat enters per cycle while o_out is not stalled; each passes through 7 transform
// stages, then the projection unit: multiply, offset, setup, 18 divider steps, output stage.
// The divider is one quotient bit per stage, which sets the depth.
// Reset clears the stage valid bits and loads the register defaults.
// A stall on o_out freezes every stage but the extrinsic matrix; i_in.ready drops with it.
`default_nettype none
module imu_camera_point_projection #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    icpp_in_if.sink          i_in,
    icpp_out_if.source       o_out
);
    localparam int IW  = COORD_WIDTH + 2;
    localparam int DW  = ((IW > 16) ? IW : 16) + 1;
    localparam int LAT = 11 + icpp_pkg::QBITS;

    logic [15:0] r_focal_x;
    logic [15:0] r_focal_y;
    logic [15:0] r_center_x;
    logic [15:0] r_center_y;
    logic [63:0] r_ext_rot;
    logic [47:0] r_ext_trans;

    logic           en;
    logic [LAT-1:0] r_vld;

    logic signed [63:0]   n_psat [3];
    logic signed [IW-1:0] r_p1 [3];
    logic signed [IW-1:0] r_p2 [3];
    icpp_pkg::t_ent       att_mat [9];
    icpp_pkg::t_ent       ext_mat [9];
    logic signed [IW-1:0] a_vec [3];
    logic signed [15:0]   te [3];
    logic signed [DW-1:0] n_diff [3];
    logic signed [63:0]   n_dsat [3];
    logic signed [IW-1:0] r_b [3];
    logic signed [IW-1:0] c_vec [3];
    logic                 behind;
    logic                 clip_u;
    logic                 clip_v;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x   <= 16'd16000;
            r_focal_y   <= 16'd16000;
            r_center_x  <= 16'd10240;
            r_center_y  <= 16'd7680;
            r_ext_rot   <= {16'd16384, 48'd0};
            r_ext_trans <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                icpp_pkg::CFG_FOCAL_X:   r_focal_x   <= i_cfg_data[15:0];
                icpp_pkg::CFG_FOCAL_Y:   r_focal_y   <= i_cfg_data[15:0];
                icpp_pkg::CFG_CENTER_X:  r_center_x  <= i_cfg_data[15:0];
                icpp_pkg::CFG_CENTER_Y:  r_center_y  <= i_cfg_data[15:0];
                icpp_pkg::CFG_EXT_ROT:   r_ext_rot   <= i_cfg_data;
                icpp_pkg::CFG_EXT_TRANS: r_ext_trans <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // Advance all stages but the extrinsic matrix unless the output beat is held
    assign en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // Clamp the point to the inner width and delay it alongside the matrix
    always_comb begin
        n_psat[0] = icpp_pkg::sat64(64'(i_in.point_x), IW);
        n_psat[1] = icpp_pkg::sat64(64'(i_in.point_y), IW);
        n_psat[2] = icpp_pkg::sat64(64'(i_in.point_z), IW);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= n_psat[i][IW-1:0];
                r_p2[i] <= r_p1[i];
            end
        end
    end

    icpp_qmat u_att_mat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_w   (i_in.att_w),
        .i_x   (i_in.att_x),
        .i_y   (i_in.att_y),
        .i_z   (i_in.att_z),
        .o_mat (att_mat)
    );

    // Extrinsic matrix follows the register contents
    icpp_qmat u_ext_mat (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_w   (r_ext_rot[63:48]),
        .i_x   (r_ext_rot[47:32]),
        .i_y   (r_ext_rot[31:16]),
        .i_z   (r_ext_rot[15:0]),
        .o_mat (ext_mat)
    );

    icpp_rot #(.IW(IW)) u_rot_att (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mat (att_mat),
        .i_vec (r_p2),
        .o_vec (a_vec)
    );

    // Subtract the camera offset and clamp
    assign te[0] = r_ext_trans[47:32];
    assign te[1] = r_ext_trans[31:16];
    assign te[2] = r_ext_trans[15:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_diff[i] = DW'(a_vec[i]) - DW'(te[i]);
            n_dsat[i] = icpp_pkg::sat64(64'(n_diff[i]), IW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b[i] <= n_dsat[i][IW-1:0];
            end
        end
    end

    icpp_rot #(.IW(IW)) u_rot_ext (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mat (ext_mat),
        .i_vec (r_b),
        .o_vec (c_vec)
    );

    assign behind = c_vec[2] <= 0;

    icpp_proj #(.IW(IW)) u_proj_u (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_kill   (behind),
        .i_focal  (r_focal_x),
        .i_center (r_center_x),
        .i_lat    (c_vec[0]),
        .i_depth  (c_vec[2]),
        .o_pix    (o_out.pixel_u),
        .o_clip   (clip_u)
    );

    icpp_proj #(.IW(IW)) u_proj_v (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_kill   (behind),
        .i_focal  (r_focal_y),
        .i_center (r_center_y),
        .i_lat    (c_vec[1]),
        .i_depth  (c_vec[2]),
        .o_pix    (o_out.pixel_v),
        .o_clip   (clip_v)
    );

    // Carry the depth flag alongside the projection stages
    logic [icpp_pkg::QBITS+3:0] r_behind;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_behind <= {r_behind[icpp_pkg::QBITS+2:0], behind};
        end
    end

    assign o_out.valid         = r_vld[LAT-1];
    assign o_out.behind_camera = r_behind[icpp_pkg::QBITS+3];
    assign o_out.clipped       = clip_u | clip_v;
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the IMU point to camera pixel projection pipeline.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int IW = CW + 2;
    localparam int LATENCY = 29;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] w, x, y, z;
        logic signed [15:0] px, py, pz;
    } t_point_beat;

    typedef struct packed {
        logic signed [15:0] u, v;
        logic               behind;
        logic               clipped;
    } t_pixel_beat;

    typedef struct {
        t_point_beat beat;
        logic        has_pixel;
        t_pixel_beat pixel;
    } t_table_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    icpp_in_if  in_ch ();
    icpp_out_if out_ch ();

    imu_camera_point_projection #(.COORD_WIDTH(CW)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Shadow copy of the register file
    logic [15:0] fx_reg, fy_reg, cx_reg, cy_reg;
    logic [63:0] ext_rot_reg;
    logic [47:0] ext_trans_reg;

    t_pixel_beat pixels_due[$];
    int          n_errors;
    int          idle_cycles;
    int          send_idle_pct, recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Predictor: floor shift and saturation helpers
    function automatic longint floor_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits, ref logic hit);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Rotate a vector by the transpose of a quaternion's rotation matrix
    function automatic void rotate_transpose(input longint q[4], input longint vin[3],
                                             output longint vout[3]);
        longint w, x, y, z, one, s;
        longint m[3][3];
        logic dummy;
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        one = 64'sd1 <<< 28;
        m[0][0] = one - 2 * (y * y + z * z);
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = one - 2 * (x * x + z * z);
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = one - 2 * (x * x + y * y);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = floor_shr(m[i][j] + icpp_pkg::RND_HALF, icpp_pkg::FRAC);
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += m[j][i] * vin[j];
            dummy = 1'b0;
            vout[i] = clamp_bits(floor_shr(s + icpp_pkg::RND_HALF, icpp_pkg::FRAC), IW,
                                 dummy);
        end
    endfunction

    // Pinhole division, rounded half away from zero, plus centre
    function automatic longint pinhole(input longint focal, input longint centre,
                                       input longint lat, input longint depth,
                                       ref logic hit);
        longint num, mag, q;
        num = focal * lat;
        mag = (num < 0) ? -num : num;
        q = (mag + depth / 2) / depth;
        if (num < 0)
            q = -q;
        return clamp_bits(q + centre, 16, hit);
    endfunction

    function automatic t_pixel_beat project_point(input t_point_beat b);
        longint qa[4], qe[4], te[3], p[3], a[3], c[3];
        logic hit, dummy;
        t_pixel_beat r;
        qa[0] = b.w; qa[1] = b.x; qa[2] = b.y; qa[3] = b.z;
        p[0] = b.px; p[1] = b.py; p[2] = b.pz;
        for (int i = 0; i < 4; i++)
            qe[i] = longint'($signed(ext_rot_reg[63 - 16 * i -: 16]));
        for (int i = 0; i < 3; i++)
            te[i] = longint'($signed(ext_trans_reg[47 - 16 * i -: 16]));
        rotate_transpose(qa, p, a);
        dummy = 1'b0;
        for (int i = 0; i < 3; i++)
            a[i] = clamp_bits(a[i] - te[i], IW, dummy);
        rotate_transpose(qe, a, c);
        hit = 1'b0;
        r = '0;
        if (c[2] <= 0) begin
            r.behind = 1'b1;
        end else begin
            r.u = 16'(pinhole(longint'(fx_reg), longint'(cx_reg), c[0], c[2], hit));
            r.v = 16'(pinhole(longint'(fy_reg), longint'(cy_reg), c[1], c[2], hit));
            r.clipped = hit;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // Check each output beat against the oldest expectation
    always @(posedge i_clk) begin
        t_pixel_beat want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.pixel_u, out_ch.pixel_v, out_ch.behind_camera, out_ch.clipped};
            if (pixels_due.size() == 0) begin
                report_mismatch("unexpected beat u", got.u, 0);
            end else begin
                want = pixels_due.pop_front();
                if (got.u !== want.u) report_mismatch("pixel_u", got.u, want.u);
                if (got.v !== want.v) report_mismatch("pixel_v", got.v, want.v);
                if (got.behind !== want.behind)
                    report_mismatch("behind_camera", got.behind, want.behind);
                if (got.clipped !== want.clipped)
                    report_mismatch("clipped", got.clipped, want.clipped);
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            icpp_pkg::CFG_FOCAL_X:   fx_reg = data[15:0];
            icpp_pkg::CFG_FOCAL_Y:   fy_reg = data[15:0];
            icpp_pkg::CFG_CENTER_X:  cx_reg = data[15:0];
            icpp_pkg::CFG_CENTER_Y:  cy_reg = data[15:0];
            icpp_pkg::CFG_EXT_ROT:   ext_rot_reg = data;
            icpp_pkg::CFG_EXT_TRANS: ext_trans_reg = data[47:0];
            default: ;
        endcase
    endtask

    // Drive one beat; hold valid until accepted, leave it high for the next
    task automatic send_point(input t_point_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.att_w   <= b.w;
        in_ch.att_x   <= b.x;
        in_ch.att_y   <= b.y;
        in_ch.att_z   <= b.z;
        in_ch.point_x <= b.px;
        in_ch.point_y <= b.py;
        in_ch.point_z <= b.pz;
        do @(posedge i_clk); while (!in_ch.ready);
        pixels_due.push_back(project_point(b));
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Random beat: mostly bounded quaternion and point values, some raw noise
    function automatic t_point_beat random_point();
        t_point_beat b;
        int k;
        k = $urandom_range(99);
        b = t_point_beat'(112'({$urandom, $urandom, $urandom, $urandom}));
        if (k < 70) begin
            b.w = 16'($signed($urandom_range(32768)) - 16384);
            b.x = 16'($signed($urandom_range(16384)) - 8192);
            b.y = 16'($signed($urandom_range(16384)) - 8192);
            b.z = 16'($signed($urandom_range(16384)) - 8192);
            b.px = 16'($signed($urandom_range(4000)) - 2000);
            b.py = 16'($signed($urandom_range(4000)) - 2000);
            b.pz = 16'($signed($urandom_range(30000)) - 5000);
        end
        return b;
    endfunction

    function automatic logic [63:0] random_quat();
        logic [63:0] q;
        q = {$urandom, $urandom};
        if ($urandom_range(3) != 0)
            q = {16'($urandom_range(16384) + 8192), 16'($signed($urandom_range(8192)) - 4096),
                 16'($signed($urandom_range(8192)) - 4096),
                 16'($signed($urandom_range(8192)) - 4096)};
        return q;
    endfunction

    localparam logic signed [15:0] ONE_Q = 16'sd16384;
    localparam logic signed [15:0] S_MAX = 16'sh7fff;
    localparam logic signed [15:0] S_MIN = 16'sh8000;

    t_table_row directed[] = '{
        // identity, point on the optical axis lands on the principal point
        '{'{ONE_Q, 0, 0, 0, 0, 0, 16'sd1000}, 1'b1, '{16'sd10240, 16'sd7680, 1'b0, 1'b0}},
        // zero depth
        '{'{ONE_Q, 0, 0, 0, 16'sd5, 16'sd5, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        // negative depth
        '{'{ONE_Q, 0, 0, 0, 16'sd5, 16'sd5, S_MIN}, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        // far off-axis point at unit depth saturates high
        '{'{ONE_Q, 0, 0, 0, S_MAX, S_MAX, 16'sd1}, 1'b1, '{S_MAX, S_MAX, 1'b0, 1'b1}},
        // and low
        '{'{ONE_Q, 0, 0, 0, S_MIN, S_MIN, 16'sd1}, 1'b1, '{S_MIN, S_MIN, 1'b0, 1'b1}},
        // zero quaternion: rotation is identity
        '{'{0, 0, 0, 0, 0, 0, 16'sd500}, 1'b1, '{16'sd10240, 16'sd7680, 1'b0, 1'b0}},
        '{'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1'b0, '{0, 0, 0, 0}},
        '{'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1'b0, '{0, 0, 0, 0}},
        '{'{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN}, 1'b0, '{0, 0, 0, 0}},
        '{'{16'sd11585, 16'sd11585, 0, 0, 16'sd100, 16'sd200, 16'sd300}, 1'b0, '{0, 0, 0, 0}},
        '{'{16'sd11585, 0, 16'sd11585, 0, -16'sd100, 16'sd50, 16'sd3000}, 1'b0, '{0, 0, 0, 0}},
        '{'{16'sd11585, 0, 0, -16'sd11585, 16'sd7, -16'sd9, 16'sd2}, 1'b0, '{0, 0, 0, 0}},
        '{'{0, ONE_Q, 0, 0, 16'sd10, 16'sd10, -16'sd400}, 1'b0, '{0, 0, 0, 0}},
        '{'{ONE_Q, 0, 0, 0, -16'sd3, 16'sd3, 16'sd2}, 1'b0, '{0, 0, 0, 0}},
        '{'{ONE_Q, 0, 0, 0, 16'sd1, -16'sd1, 16'sd2}, 1'b0, '{0, 0, 0, 0}}
    };

    initial begin
        t_point_beat b;
        t_pixel_beat want;
        n_errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fx_reg = 16'd16000; fy_reg = 16'd16000;
        cx_reg = 16'd10240; cy_reg = 16'd7680;
        ext_rot_reg = 64'd16384 << 48;
        ext_trans_reg = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = icpp_pkg::CFG_FOCAL_X; i_cfg_data = '0;
        in_ch.valid = 1'b0;
        {in_ch.att_w, in_ch.att_x, in_ch.att_y, in_ch.att_z} = '0;
        {in_ch.point_x, in_ch.point_y, in_ch.point_z} = '0;
        out_ch.ready = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at reset settings
        foreach (directed[i]) begin
            b = directed[i].beat;
            want = project_point(b);
            if (directed[i].has_pixel && want !== directed[i].pixel)
                report_mismatch("table row", i, i);
            send_point(b);
        end
        drain();

        // Extremes of every register, plus an out-of-list index that is ignored
        write_reg(icpp_pkg::CFG_FOCAL_X, 64'hffff_ffff_ffff_ffff);
        write_reg(icpp_pkg::CFG_FOCAL_Y, 64'd0);
        write_reg(icpp_pkg::CFG_CENTER_X, 64'd0);
        write_reg(icpp_pkg::CFG_CENTER_Y, 64'hffff);
        write_reg(icpp_pkg::CFG_EXT_ROT, 64'h7fff_8000_7fff_8000);
        write_reg(icpp_pkg::CFG_EXT_TRANS, 64'hffff_7fff_8000_0001);
        write_reg(3'd7, 64'h1234);
        foreach (directed[i]) send_point(directed[i].beat);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 16; recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 16; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase == 7) begin
                write_reg(icpp_pkg::CFG_FOCAL_X, 64'd16000);
                write_reg(icpp_pkg::CFG_FOCAL_Y, 64'd16000);
                write_reg(icpp_pkg::CFG_CENTER_X, 64'd10240);
                write_reg(icpp_pkg::CFG_CENTER_Y, 64'd7680);
                write_reg(icpp_pkg::CFG_EXT_ROT, 64'd16384 << 48);
                write_reg(icpp_pkg::CFG_EXT_TRANS, 64'd0);
            end else begin
                write_reg(icpp_pkg::CFG_FOCAL_X, 64'($urandom_range(65535)));
                write_reg(icpp_pkg::CFG_FOCAL_Y, 64'($urandom_range(65535)));
                write_reg(icpp_pkg::CFG_CENTER_X, 64'($urandom_range(65535)));
                write_reg(icpp_pkg::CFG_CENTER_Y, 64'($urandom_range(65535)));
                write_reg(icpp_pkg::CFG_EXT_ROT, random_quat());
                write_reg(icpp_pkg::CFG_EXT_TRANS,
                          {16'($urandom), 48'($signed($urandom_range(400)) - 200)
                           | (48'($urandom) & 48'hffff_ffff_0000)});
            end
            for (int n = 0; n < 100; n++) begin
                // pause once until the pipe has emptied
                if (phase == 2 && n == 50) begin
                    in_ch.valid <= 1'b0;
                    while (pixels_due.size() != 0) @(posedge i_clk);
                end
                send_point(random_point());
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
